// ===== design/sfhl_pkg.sv =====
// Package: shared constants and types for the surface friction lookup unit.
package sfhl_pkg;
    localparam int MaxSurfaces = 256;
    localparam int MaxTires    = 16;
    localparam int KeyBits     = 48;
    localparam int SurfBits    = 8;
    localparam int TireBits    = 4;
    localparam int FricBits    = 16;
    localparam int TableDepth  = MaxSurfaces * MaxTires;
    localparam int TableBits   = 12;
    localparam logic [FricBits-1:0] FricOne = 16'd4096;

    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_SETF   = 3'd1;
    localparam logic [2:0] MODE_KEY    = 3'd2;
    localparam logic [2:0] MODE_SURF   = 3'd3;
    localparam logic [2:0] MODE_REINIT = 3'd4;

    localparam logic REG_TIRE = 1'b0;
    localparam logic REG_SURF = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  entry_index;
        logic [47:0] material_key;
        logic [7:0]  entry_surface_type;
        logic [7:0]  surface_index;
        logic [3:0]  tire_index;
        logic [15:0] friction_in;
    } t_req;

    typedef struct packed {
        logic [7:0]  found_surface_type;
        logic [15:0] friction_out;
        logic        index_in_range;
    } t_rsp;

    // Bucket of a key for a given shift; a shift of 64 or more gives bucket 0.
    function automatic logic [SurfBits-1:0] bucket_of(input logic [KeyBits-1:0] key,
                                                       input logic [6:0] shift);
        logic [KeyBits-1:0] s;
        s = key >> shift;
        return shift[6] ? '0 : s[SurfBits-1:0];
    endfunction
endpackage

// ===== design/sfhl_if.sv =====
// Interfaces: valid/ready channel carrying request or response payload.
interface sfhl_req_if import sfhl_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sfhl_rsp_if import sfhl_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/surface_friction_hash_lookup_unit.sv =====
// Top level: surface friction lookup with a chained key hash.
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        t_req (mode, keys, indices, friction)
//  o_rsp     out  valid/ready        t_rsp (found type, friction, in-range)
//  apb       in   psel/penable/...   tire_type_count @0, surface_type_count @4
//
// Transfer path: a load is taken in S_IDLE, set friction passes S_FRD, lookup by type
// passes S_FRD, S_FOUT and S_OUT; a key lookup adds S_HEAD and S_HRD, then S_WALK and
// S_CMP for each chain entry compared. A key lookup after any key load or accepted
// register write first rebuilds the hash: up to six shift trials over all N keys,
// then a clear of all 256 bucket heads and a link pass over the N keys. Reinit
// sweeps 4096 table words, one a cycle.
// Reset: a fill of all 4096 friction table words with 1.0 runs first; no
// transfer is accepted meanwhile. A result waiting on o_rsp stalls the unit.
module surface_friction_hash_lookup_unit import sfhl_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sfhl_req_if.sink     i_req,
    sfhl_rsp_if.source   o_rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    typedef enum logic [3:0] {
        S_FILL, S_IDLE, S_TRIAL, S_CLR, S_LINK, S_LRD, S_LWR, S_HEAD, S_HRD,
        S_WALK, S_CMP, S_FRD, S_FOUT, S_OUT
    } t_state;

    t_state              r_state;
    logic [4:0]          r_tires;
    logic [8:0]          r_surfs;
    logic                r_stale;
    logic [6:0]          r_shift, r_prev_shift, r_try;
    logic [8:0]          r_prev_cnt, r_cnt;
    logic [8:0]          r_i;          // sweep index (N up to 256)
    logic [12:0]         r_fill;
    logic                r_rd_pend;
    t_req                r_req;
    t_rsp                r_rsp;
    logic [8:0]          r_id;
    logic [7:0]          r_found;
    logic [7:0]          r_surf;

    // key and type stores: written by loads, read at one address
    logic [KeyBits-1:0]  r_keys [MaxSurfaces];
    logic [7:0]          r_types [MaxSurfaces];
    logic [KeyBits-1:0]  r_key_q;
    logic [7:0]          r_type_q;
    logic [7:0]          w_kaddr;
    // bucket heads and links, 9-bit entries with 256 = end
    logic [8:0]          r_heads [MaxSurfaces];
    logic [8:0]          r_links [MaxSurfaces];
    logic [8:0]          r_head_q, r_link_q;
    logic [7:0]          w_haddr;
    logic                w_hwe;
    logic [7:0]          w_hwaddr;
    logic [8:0]          w_hwdata;
    logic                w_lwe;
    logic [8:0]          w_lwdata;
    // seen bits for distinct-bucket counting
    logic [MaxSurfaces-1:0] r_seen;

    logic                w_in_acc, w_out_acc, w_cfg_wr;
    logic [7:0]          w_bkt;
    logic                w_fwe;
    logic [TableBits-1:0] w_fwaddr, w_fraddr;
    logic [FricBits-1:0] w_fwdata, w_frdata;
    logic                w_ok;
    logic [12:0]         w_prod;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign prdata    = paddr[2] ? {23'd0, r_surfs} : {27'd0, r_tires};
    assign w_in_acc  = i_req.valid && i_req.ready;
    assign w_out_acc = o_rsp.valid && o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data  = r_rsp;

    // key store address: loading uses the request index, sweeps use r_i, walks r_id
    always_comb begin
        w_kaddr = r_i[7:0];
        if (r_state == S_WALK || r_state == S_CMP) begin
            w_kaddr = r_id[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_req.data.mode == MODE_LOAD) begin
            r_keys[i_req.data.entry_index]  <= i_req.data.material_key;
            r_types[i_req.data.entry_index] <= i_req.data.entry_surface_type;
        end
        r_key_q  <= r_keys[w_kaddr];
        r_type_q <= r_types[w_kaddr];
    end

    assign w_haddr = (r_state == S_HEAD) ? bucket_of(r_req.material_key, r_shift)
                                         : bucket_of(r_key_q, r_shift);
    always_comb begin
        w_hwe    = 1'b0;
        w_hwaddr = r_i[7:0];
        w_hwdata = 9'(MaxSurfaces);
        w_lwe    = 1'b0;
        w_lwdata = r_head_q;
        if (r_state == S_CLR) begin
            w_hwe = 1'b1;
        end else if (r_state == S_LWR) begin
            w_hwe    = 1'b1;
            w_hwaddr = bucket_of(r_key_q, r_shift);
            w_hwdata = r_i;       // entry index of the key just read
            w_lwe    = 1'b1;
        end
    end

    // Heads and links are read through registers; the link pass steps each entry
    // through S_LINK, S_LRD and S_LWR so each head read sees the previous insert.
    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_heads[w_hwaddr] <= w_hwdata;
        end
        if (w_lwe) begin
            r_links[r_i[7:0]] <= w_lwdata;
        end
        r_head_q <= r_heads[w_haddr];
        r_link_q <= r_links[r_id[7:0]];
    end

    assign w_prod   = 13'(r_tires) * 13'(r_surf);
    assign w_ok     = (13'(r_req.tire_index) < 13'(r_tires)) && (9'(r_surf) < r_surfs);
    assign w_fraddr = w_prod[TableBits-1:0] + TableBits'(r_req.tire_index);
    always_comb begin
        w_fwe    = 1'b0;
        w_fwaddr = r_fill[TableBits-1:0];
        w_fwdata = FricOne;
        if (r_state == S_FILL) begin
            w_fwe = 1'b1;
        end else if (r_state == S_FRD && r_req.mode == MODE_SETF) begin
            w_fwe    = w_ok;
            w_fwaddr = w_fraddr;
            w_fwdata = r_req.friction_in;
        end
    end

    sfhl_fric_mem u_fric (
        .i_clk   (i_clk),
        .i_we    (w_fwe),
        .i_waddr (w_fwaddr),
        .i_wdata (w_fwdata),
        .i_raddr (w_fraddr),
        .o_rdata (w_frdata)
    );

    assign w_bkt = bucket_of(r_key_q, r_try);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_fill  <= '0;
            r_tires <= '0;
            r_surfs <= '0;
            r_stale <= 1'b1;
            r_shift <= '0;
            r_i     <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                if (paddr[2] == REG_SURF) begin
                    if (pwdata[8:0] <= 9'(MaxSurfaces)) begin
                        r_surfs <= pwdata[8:0];
                        r_stale <= 1'b1;
                    end
                end else if (pwdata[4:0] <= 5'(MaxTires)) begin
                    r_tires <= pwdata[4:0];
                    r_stale <= 1'b1;
                end
            end
            case (r_state)
                S_FILL: begin
                    r_fill <= r_fill + 13'd1;
                    if (r_fill == 13'(TableDepth - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_req <= i_req.data;
                        // a key lookup that misses reads row 0
                        r_surf <= (i_req.data.mode == MODE_KEY) ? '0
                                                                : i_req.data.surface_index;
                        r_found <= '0;
                        r_fill <= '0;
                        case (i_req.data.mode)
                            MODE_LOAD:   r_stale <= 1'b1;
                            MODE_SETF:   r_state <= S_FRD;
                            MODE_SURF:   r_state <= S_FRD;
                            MODE_REINIT: r_state <= S_FILL;
                            MODE_KEY: begin
                                if (r_stale) begin
                                    r_shift <= '0;
                                    r_prev_shift <= '0;
                                    r_prev_cnt <= '0;
                                    r_try <= 7'd2;
                                    r_i <= '0;
                                    r_cnt <= '0;
                                    r_seen <= '0;
                                    r_rd_pend <= 1'b0;
                                    r_state <= (r_surfs == '0) ? S_CLR : S_TRIAL;
                                end else begin
                                    r_state <= S_HEAD;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                // count distinct buckets for shift r_try, one key a cycle
                S_TRIAL: begin
                    if (r_rd_pend) begin
                        if (!r_seen[w_bkt]) begin
                            r_seen[w_bkt] <= 1'b1;
                            r_cnt <= r_cnt + 9'd1;
                        end
                    end
                    if (r_i < r_surfs) begin
                        r_i <= r_i + 9'd1;
                        r_rd_pend <= 1'b1;
                    end else if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;   // last compare lands this cycle
                    end else begin
                        r_seen <= '0;
                        r_i <= '0;
                        r_cnt <= '0;
                        if (r_cnt > r_prev_cnt && r_cnt != r_surfs && !r_try[6]) begin
                            r_prev_cnt <= r_cnt;
                            r_prev_shift <= r_try;
                            r_try <= r_try << 1;
                        end else begin
                            // a shift doubled to 64 still means bucket 0
                            r_shift <= (r_cnt == r_surfs) ? r_try : r_prev_shift;
                            r_state <= S_CLR;
                        end
                    end
                end
                S_CLR: begin
                    r_i <= r_i + 9'd1;
                    if (r_i == 9'(MaxSurfaces - 1)) begin
                        r_i <= '0;
                        r_cnt <= '0;
                        r_rd_pend <= 1'b0;
                        r_state <= S_LINK;
                    end
                end
                // read key r_i, or finish once every entry is chained
                S_LINK: begin
                    if (r_i < r_surfs) begin
                        r_state <= S_LRD;
                    end else begin
                        r_stale <= 1'b0;
                        r_state <= S_HEAD;
                    end
                end
                // hold the entry while its bucket head is read
                S_LRD: r_state <= S_LWR;
                // insert entry r_i in front of its bucket's chain
                S_LWR: begin
                    r_i <= r_i + 9'd1;
                    r_state <= S_LINK;
                end
                // read the head of the looked-up key's bucket
                S_HEAD: r_state <= S_HRD;
                S_HRD: begin
                    r_id <= r_head_q;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_state <= r_id[8] ? S_FRD : S_CMP;
                end
                S_CMP: begin
                    if (r_key_q == r_req.material_key) begin
                        r_found <= r_type_q;
                        r_surf  <= r_type_q;
                        r_state <= S_FRD;
                    end else begin
                        r_id <= r_link_q;
                        r_state <= S_WALK;
                    end
                end
                S_FRD: begin
                    if (r_req.mode == MODE_SETF) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_rsp.found_surface_type <= r_found;
                        r_rsp.index_in_range <= w_ok;
                        r_state <= S_FOUT;
                    end
                end
                S_FOUT: begin
                    r_rsp.friction_out <= r_rsp.index_in_range ? w_frdata : '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_acc) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/sfhl_fric_mem.sv =====
// Friction table memory: one write port, one registered read port.
module sfhl_fric_mem import sfhl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [TableBits-1:0] i_waddr,
    input  logic [FricBits-1:0]  i_wdata,
    input  logic [TableBits-1:0] i_raddr,
    output logic [FricBits-1:0]  o_rdata
);
    logic [FricBits-1:0] r_mem [TableDepth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/sfhl_checker.sv =====
// Checker: port-level properties of the friction lookup unit.
module sfhl_checker import sfhl_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input t_rsp out_data
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.index_in_range |-> out_data.friction_out == '0)
        else $error("friction without range");
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready |=> in_ready) else $error("not ready after result");
endmodule

bind surface_friction_hash_lookup_unit sfhl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(i_req.ready),
    .out_valid(o_rsp.valid), .out_ready(o_rsp.ready), .out_data(o_rsp.data)
);

// ===== verif/testbench.sv =====
// Testbench for the surface friction lookup unit: directed table plus random traffic.
`timescale 1ns / 100ps

module testbench;
    import sfhl_pkg::*;

    localparam int NoEntry = 256;
    localparam int ReqBits = $bits(t_req);
    // Reinit sweeps 4096 words; allow that plus margin before any register write.
    localparam int DrainCycles = 5000;
    // modes the unit accepts and ignores
    localparam logic [2:0] MODE_SPARE_A = 3'd5;
    localparam logic [2:0] MODE_SPARE_B = 3'd6;
    localparam logic [2:0] MODE_SPARE_C = 3'd7;

    typedef struct {
        t_req req;
        bit   typed;   // expected result typed in below rather than predicted
        t_rsp rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    sfhl_req_if req_ch ();
    sfhl_rsp_if rsp_ch ();

    surface_friction_hash_lookup_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the unit's state for prediction.
    logic [47:0] shadow_keys [NoEntry];
    logic [7:0]  shadow_types [NoEntry];
    logic [15:0] shadow_fric [TableDepth];
    int          shadow_heads [NoEntry];
    int          shadow_links [NoEntry];
    int          shadow_shift;
    bit          shadow_stale;
    int          tire_count, surf_count;

    t_rsp expected_lookups [$];
    t_row dir_rows [$];
    int   mismatches = 0;
    int   send_idle = 0, recv_stall = 0;

    function automatic int key_bucket(logic [47:0] key, int sh);
        logic [47:0] s;
        if (sh >= 64) return 0;
        s = key >> sh;
        return int'(s[7:0]);
    endfunction

    function automatic int bucket_spread(int sh);
        bit seen [NoEntry];
        int n;
        n = 0;
        for (int i = 0; i < NoEntry; i++) seen[i] = 0;
        for (int i = 0; i < surf_count; i++) begin
            if (!seen[key_bucket(shadow_keys[i], sh)]) begin
                seen[key_bucket(shadow_keys[i], sh)] = 1;
                n++;
            end
        end
        return n;
    endfunction

    // Pick the shift, then chain every entry newest first into its bucket.
    function automatic void rehash();
        int prev_shift, sh, prev_cnt, cur, b;
        for (int i = 0; i < NoEntry; i++) begin
            shadow_heads[i] = NoEntry;
            shadow_links[i] = NoEntry;
        end
        shadow_shift = 0;
        if (surf_count > 0) begin
            prev_shift = 0;
            sh = 2;
            prev_cnt = 0;
            forever begin
                cur = bucket_spread(sh);
                if (!(cur > prev_cnt && cur != surf_count)) break;
                prev_cnt = cur;
                prev_shift = sh;
                sh = sh << 1;
            end
            shadow_shift = (cur == surf_count) ? sh : prev_shift;
            for (int i = 0; i < surf_count; i++) begin
                b = key_bucket(shadow_keys[i], shadow_shift);
                shadow_links[i] = shadow_heads[b];
                shadow_heads[b] = i;
            end
        end
        shadow_stale = 0;
    endfunction

    function automatic logic [7:0] chain_search(logic [47:0] key);
        int id, steps;
        steps = 0;
        id = shadow_heads[key_bucket(key, shadow_shift)];
        while (id < NoEntry && steps < NoEntry) begin
            if (shadow_keys[id] == key) return shadow_types[id];
            id = shadow_links[id];
            steps++;
        end
        return 8'd0;
    endfunction

    function automatic bit indices_ok(int surf, int tire);
        return tire < tire_count && surf < surf_count;
    endfunction

    // Update the shadow state for one transfer; return 1 with a result for lookups.
    function automatic bit predict_lookup(t_req r, output t_rsp rsp);
        int surf, tire;
        surf = int'(r.surface_index);
        tire = int'(r.tire_index);
        rsp = '0;
        case (r.mode)
            MODE_LOAD: begin
                shadow_keys[r.entry_index] = r.material_key;
                shadow_types[r.entry_index] = r.entry_surface_type;
                shadow_stale = 1;
                return 0;
            end
            MODE_SETF: begin
                if (indices_ok(surf, tire)) shadow_fric[tire_count * surf + tire] = r.friction_in;
                return 0;
            end
            MODE_KEY: begin
                if (shadow_stale) rehash();
                rsp.found_surface_type = chain_search(r.material_key);
                surf = int'(rsp.found_surface_type);
            end
            MODE_SURF: ;
            MODE_REINIT: begin
                for (int i = 0; i < TableDepth; i++) shadow_fric[i] = FricOne;
                return 0;
            end
            default: return 0;
        endcase
        rsp.index_in_range = indices_ok(surf, tire);
        if (rsp.index_in_range) rsp.friction_out = shadow_fric[tire_count * surf + tire];
        return 1;
    endfunction

    function automatic t_req req_of(logic [2:0] mode, int entry, logic [47:0] key, int etype,
                                    int surf, int tire, int fin);
        t_req r;
        r.mode = mode;
        r.entry_index = 8'(entry);
        r.material_key = key;
        r.entry_surface_type = 8'(etype);
        r.surface_index = 8'(surf);
        r.tire_index = 4'(tire);
        r.friction_in = 16'(fin);
        return r;
    endfunction

    function automatic void add_row(t_req r, bit typed = 0, t_rsp rsp = '0);
        t_row row;
        row.req = r;
        row.typed = typed;
        row.rsp = rsp;
        dir_rows.push_back(row);
    endfunction

    // Keys with shared low bits and repeats, so buckets collide and chains grow.
    function automatic logic [47:0] fresh_key();
        logic [47:0] k;
        k = 48'({$urandom, $urandom});
        case ($urandom_range(5))
            0: k[15:0] = 16'h5A5A;
            1: k[31:0] = 32'h0;
            2: k = shadow_keys[$urandom_range(255)];
            default: ;
        endcase
        return k;
    endfunction

    function automatic t_req random_req();
        t_req r;
        int pick;
        r = t_req'(ReqBits'({$urandom, $urandom, $urandom}));
        pick = $urandom_range(99);
        if (pick < 40) r.mode = MODE_KEY;
        else if (pick < 75) r.mode = MODE_SURF;
        else if (pick < 90) r.mode = MODE_SETF;
        else if (pick < 95) r.mode = MODE_LOAD;
        else if (pick < 96) r.mode = MODE_REINIT;
        else r.mode = 3'($urandom_range(MODE_SPARE_C, MODE_SPARE_A));
        if (r.mode == MODE_LOAD) r.material_key = fresh_key();
        if (r.mode == MODE_KEY && $urandom_range(9) < 7)
            r.material_key = shadow_keys[$urandom_range(255)];
        // Keep most row indices inside the configured count.
        if (surf_count > 0 && $urandom_range(9) < 8)
            r.surface_index = 8'($urandom_range(surf_count > 256 ? 255 : surf_count - 1));
        return r;
    endfunction

    // Drive one request, hold it until the transfer, then predict.
    task automatic send_req(t_req r);
        t_rsp rsp;
        while ($urandom_range(99) < send_idle) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data = r;
        do @(posedge i_clk); while (!req_ch.ready);
        if (predict_lookup(r, rsp)) expected_lookups.push_back(rsp);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        req_ch.valid = 1'b0;
        wait (expected_lookups.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Two-phase register write; bits above the field carry noise the unit drops.
    task automatic apb_write_count(logic reg_sel, int value);
        int v;
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = (reg_sel == REG_SURF) ? 3'd4 : 3'd0;
        pwdata = {23'($urandom_range(8388607)), 9'(value)};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == REG_TIRE) begin
            v = value & 32'h1F;
            if (v <= MaxTires) begin
                tire_count = v;
                shadow_stale = 1;
            end
        end else begin
            v = value & 32'h1FF;
            if (v <= MaxSurfaces) begin
                surf_count = v;
                shadow_stale = 1;
            end
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Response side: random stall, compare each transfer with the oldest expectation.
    always @(negedge i_clk) rsp_ch.ready = ($urandom_range(99) >= recv_stall);

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_lookups.size() == 0) begin
                $display("%0t: unexpected result %p", $time, rsp_ch.data);
                mismatches++;
            end else begin
                want = expected_lookups.pop_front();
                if (rsp_ch.data.found_surface_type !== want.found_surface_type) begin
                    $display("%0t: found_surface_type expected %0d actual %0d", $time,
                             want.found_surface_type, rsp_ch.data.found_surface_type);
                    mismatches++;
                end
                if (rsp_ch.data.friction_out !== want.friction_out) begin
                    $display("%0t: friction_out expected %0d actual %0d", $time,
                             want.friction_out, rsp_ch.data.friction_out);
                    mismatches++;
                end
                if (rsp_ch.data.index_in_range !== want.index_in_range) begin
                    $display("%0t: index_in_range expected %0d actual %0d", $time,
                             want.index_in_range, rsp_ch.data.index_in_range);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #60ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        int tire_set [6] = '{16, 1, 0, 7, 16, 3};
        int surf_set [6] = '{256, 1, 256, 40, 0, 9};
        t_row row;

        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b1;
        tire_count = 0;
        surf_count = 0;
        shadow_shift = 0;
        shadow_stale = 1;
        for (int i = 0; i < TableDepth; i++) shadow_fric[i] = FricOne;
        for (int i = 0; i < NoEntry; i++) begin
            shadow_keys[i] = '0;
            shadow_types[i] = '0;
            shadow_heads[i] = NoEntry;
            shadow_links[i] = NoEntry;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Counts are zero after reset: nothing is in range and no key matches.
        add_row(req_of(MODE_SURF, 0, 48'h0, 0, 0, 0, 0), 1, '{8'd0, 16'd0, 1'b0});
        add_row(req_of(MODE_KEY, 0, '1, 0, 255, 15, 0), 1, '{8'd0, 16'd0, 1'b0});
        add_row(req_of(MODE_SETF, 0, 48'h0, 0, 0, 0, 16'hFFFF));
        add_row(req_of(MODE_SPARE_A, 255, '1, 255, 255, 15, 16'hFFFF));
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_req(row.req);
            if (row.typed) begin
                void'(expected_lookups.pop_back());
                expected_lookups.push_back(row.rsp);
            end
        end
        dir_rows.delete();

        // Fill every key entry before any count makes them visible.
        for (int i = 0; i < NoEntry; i++)
            send_req(req_of(MODE_LOAD, i, fresh_key(), $urandom_range(255), 0, 0, 0));
        go_idle();
        apb_write_count(REG_TIRE, 16);
        apb_write_count(REG_SURF, 256);

        add_row(req_of(MODE_SURF, 0, 48'h0, 0, 255, 15, 0), 1, '{8'd0, FricOne, 1'b1});
        add_row(req_of(MODE_SETF, 0, 48'h0, 0, 255, 15, 16'hFFFF));
        add_row(req_of(MODE_SURF, 0, 48'h0, 0, 255, 15, 0), 1, '{8'd0, 16'hFFFF, 1'b1});
        add_row(req_of(MODE_SETF, 0, 48'h0, 0, 0, 0, 16'h0));
        add_row(req_of(MODE_SURF, 0, 48'h0, 0, 0, 0, 0), 1, '{8'd0, 16'd0, 1'b1});
        add_row(req_of(MODE_KEY, 0, shadow_keys[17], 0, 0, 15, 0));
        // Same all-ones key in two entries: the higher index must win.
        add_row(req_of(MODE_LOAD, 255, '1, 255, 0, 0, 0));
        add_row(req_of(MODE_LOAD, 254, '1, 7, 0, 0, 0));
        add_row(req_of(MODE_KEY, 0, '1, 0, 0, 15, 0));
        add_row(req_of(MODE_KEY, 0, 48'h0, 0, 0, 0, 0));
        add_row(req_of(MODE_REINIT, 0, 48'h0, 0, 0, 0, 0));
        add_row(req_of(MODE_SURF, 0, 48'h0, 0, 255, 15, 0), 1, '{8'd0, FricOne, 1'b1});
        add_row(req_of(MODE_SPARE_C, 0, 48'h0, 0, 0, 0, 0));
        add_row(req_of(MODE_SPARE_B, 0, 48'h0, 0, 0, 0, 0));
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_req(row.req);
            if (row.typed) begin
                void'(expected_lookups.pop_back());
                expected_lookups.push_back(row.rsp);
            end
        end

        // Random phases, each with its own counts and one of four handshake pressures.
        for (int ph = 0; ph < 6; ph++) begin
            go_idle();
            if (ph == 2) begin
                apb_write_count(REG_TIRE, 17);   // too large: dropped
                apb_write_count(REG_SURF, 300);  // too large: dropped
            end
            apb_write_count(REG_TIRE, tire_set[ph]);
            apb_write_count(REG_SURF, surf_set[ph]);
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 88; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 88; end
                default: begin send_idle = 29; recv_stall = 29; end
            endcase
            for (int n = 0; n < 190; n++) send_req(random_req());
        end

        req_ch.valid = 1'b0;
        wait (expected_lookups.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0 && expected_lookups.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== surface_friction_hash_lookup_unit.f =====
design/sfhl_pkg.sv
design/sfhl_if.sv
design/sfhl_fric_mem.sv
design/surface_friction_hash_lookup_unit.sv
design/sfhl_checker.sv
verif/testbench.sv
